// File: rtl/ttq_pkg.sv
// ----------------------------------------------------------------------------
// ttq_pkg: shared types and constants of the timed task queue
// Slot count, field widths, request and status codes, result record.
// ----------------------------------------------------------------------------
package ttq_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int TOT_W      = $clog2(TASK_SLOTS + 1);

    localparam int REQ_W   = 3;
    localparam int TIME_W  = 48;
    localparam int ID_W    = 32;
    localparam int STAT_W  = 2;
    localparam int RCNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_INS_SYS   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_OWNED = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL_ID = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CANCEL_OWN = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE      = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   result_id;
        logic [ID_W-1:0]   result_owner;
        logic [RCNT_W-1:0] removed_count;
        logic              present;
        logic              last;
    } t_rsp;

endpackage

// File: rtl/ttq_req_if.sv
// ----------------------------------------------------------------------------
// ttq_req_if: request channel
// Valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface ttq_req_if import ttq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] due_time;
    logic [ID_W-1:0]   owner_id;
    logic [ID_W-1:0]   target_id;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, req_type, due_time, owner_id, target_id, now_time,
                    input ready);
    modport sink   (input valid, req_type, due_time, owner_id, target_id, now_time,
                    output ready);
endinterface

// File: rtl/ttq_rsp_if.sv
// ----------------------------------------------------------------------------
// ttq_rsp_if: result channel
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface ttq_rsp_if import ttq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   result_id;
    logic [ID_W-1:0]   result_owner;
    logic [RCNT_W-1:0] removed_count;
    logic              present;
    logic              last;

    modport source (output valid, status, result_id, result_owner, removed_count,
                    present, last, input ready);
    modport sink   (input valid, status, result_id, result_owner, removed_count,
                    present, last, output ready);
endinterface

// File: rtl/ttq_order.sv
// ----------------------------------------------------------------------------
// ttq_order: firing order compare
// True when a candidate slot goes before the current best (earlier due,
// ties to the lower id).
// ----------------------------------------------------------------------------
module ttq_order import ttq_pkg::*; (
    input  logic [TIME_W-1:0] i_cand_due,
    input  logic [ID_W-1:0]   i_cand_id,
    input  logic [TIME_W-1:0] i_best_due,
    input  logic [ID_W-1:0]   i_best_id,
    input  logic              i_best_found,
    output logic              o_before
);
    assign o_before = !i_best_found || (i_cand_due < i_best_due) ||
                      ((i_cand_due == i_best_due) && (i_cand_id < i_best_id));
endmodule

// File: rtl/timed_task_queue.sv
// ----------------------------------------------------------------------------
// timed_task_queue: table of timed tasks with cancel, tick and query
// Slots are visited one per cycle by a small sequencer sharing one compare.
// ----------------------------------------------------------------------------
// Steps: an insert goes through S_INS and S_EMIT to the result register, an
//   unknown request straight through S_EMIT; cancel/query scan every slot;
//   tick scans every slot for the due count, then a further scan of every
//   slot per fired task picks it; when nothing is due the count scan ends it.
// Throughput: one request at a time, ready only in idle; the next request
//   waits until every result of the last one is in the output register.
// Reset: synchronous, active low; clears all valid bits, the id counter and
//   the sequencer. Slot contents are not cleared, they are read only if valid.
module timed_task_queue import ttq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ttq_req_if.sink   i_req,
    ttq_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {S_IDLE, S_INS, S_SCAN, S_PICK, S_EMIT} t_state;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    t_state r_state;

    // latched request
    logic [REQ_W-1:0]  r_req;
    logic [TIME_W-1:0] r_due_in;
    logic [ID_W-1:0]   r_owner_in;
    logic [ID_W-1:0]   r_target;
    logic [TIME_W-1:0] r_now;

    // task table
    logic [TASK_SLOTS-1:0] r_valid;
    logic [TIME_W-1:0]     r_slot_due   [TASK_SLOTS];
    logic [ID_W-1:0]       r_slot_owner [TASK_SLOTS];
    logic [ID_W-1:0]       r_slot_id    [TASK_SLOTS];
    logic [ID_W-1:0]       r_id_ctr;

    // scan state
    logic [SLOT_W-1:0] r_idx;
    logic              r_hit;
    logic [RCNT_W-1:0] r_rcnt;
    logic [TOT_W-1:0]  r_total;
    logic [TOT_W-1:0]  r_fired;
    logic              r_found;
    logic [SLOT_W-1:0] r_best;
    logic [TIME_W-1:0] r_best_due;
    logic [ID_W-1:0]   r_best_id;
    logic              r_more;

    // result staging and output register
    t_rsp r_res;
    t_rsp r_out;
    logic r_out_valid;

    // insert write port
    logic              w_wr;
    logic [SLOT_W-1:0] w_free;
    logic              w_free_ok;
    logic [ID_W-1:0]   w_nid;

    // current slot under the scan
    logic              cur_valid;
    logic [TIME_W-1:0] cur_due;
    logic [ID_W-1:0]   cur_owner;
    logic [ID_W-1:0]   cur_id;
    logic              cur_due_ok;
    logic              cur_before;

    assign cur_valid  = r_valid[r_idx];
    assign cur_due    = r_slot_due[r_idx];
    assign cur_owner  = r_slot_owner[r_idx];
    assign cur_id     = r_slot_id[r_idx];
    assign cur_due_ok = cur_valid && (cur_due <= r_now);

    ttq_order u_order (
        .i_cand_due   (cur_due),
        .i_cand_id    (cur_id),
        .i_best_due   (r_best_due),
        .i_best_id    (r_best_id),
        .i_best_found (r_found),
        .o_before     (cur_before)
    );

    // lowest free slot
    always_comb begin
        w_free    = '0;
        w_free_ok = 1'b0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free    = SLOT_W'(i);
                w_free_ok = 1'b1;
            end
        end
    end

    // next id, skipping zero on wrap
    assign w_nid = (r_id_ctr + 1'b1 == '0) ? ID_W'(1) : r_id_ctr + 1'b1;
    assign w_wr  = (r_state == S_INS) && w_free_ok;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot_due[w_free]   <= r_due_in;
            r_slot_owner[w_free] <= (r_req == REQ_INS_OWNED) ? r_owner_in : '0;
            r_slot_id[w_free]    <= w_nid;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.result_id     = r_out.result_id;
    assign o_rsp.result_owner  = r_out.result_owner;
    assign o_rsp.removed_count = r_out.removed_count;
    assign o_rsp.present       = r_out.present;
    assign o_rsp.last          = r_out.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_id_ctr    <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_rcnt      <= '0;
            r_total     <= '0;
            r_fired     <= '0;
            r_found     <= 1'b0;
            r_more      <= 1'b0;
        end else begin
            // S_EMIT handles the output register itself
            if (o_rsp.ready && r_state != S_EMIT) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req      <= i_req.req_type;
                        r_due_in   <= i_req.due_time;
                        r_owner_in <= i_req.owner_id;
                        r_target   <= i_req.target_id;
                        r_now      <= i_req.now_time;
                        r_idx      <= '0;
                        r_hit      <= 1'b0;
                        r_rcnt     <= '0;
                        r_total    <= '0;
                        r_fired    <= '0;
                        r_found    <= 1'b0;
                        r_more     <= 1'b0;
                        case (i_req.req_type)
                            REQ_INS_SYS, REQ_INS_OWNED: r_state <= S_INS;
                            REQ_CANCEL_ID, REQ_CANCEL_OWN,
                            REQ_TICK, REQ_QUERY: r_state <= S_SCAN;
                            default: begin
                                r_res   <= '{ST_NONE, '0, '0, '0, 1'b0, 1'b1};
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end

                S_INS: begin
                    if (w_free_ok) begin
                        r_valid[w_free] <= 1'b1;
                        r_id_ctr        <= w_nid;
                        r_res <= '{ST_OK, w_nid,
                                   (r_req == REQ_INS_OWNED) ? r_owner_in : '0,
                                   '0, 1'b0, 1'b1};
                    end else begin
                        r_res <= '{ST_FULL, '0, '0, '0, 1'b0, 1'b1};
                    end
                    r_state <= S_EMIT;
                end

                // one slot per cycle: match for cancel/query, due count for tick
                S_SCAN: begin : scan
                    logic             hit_n;
                    logic [RCNT_W-1:0] rcnt_n;
                    logic [TOT_W-1:0] tot_n;
                    hit_n  = r_hit;
                    rcnt_n = r_rcnt;
                    tot_n  = r_total;
                    case (r_req)
                        REQ_CANCEL_ID, REQ_QUERY: begin
                            if (cur_valid && r_target != '0 && cur_id == r_target) begin
                                hit_n = 1'b1;
                                if (r_req == REQ_CANCEL_ID) r_valid[r_idx] <= 1'b0;
                            end
                        end
                        REQ_CANCEL_OWN: begin
                            if (cur_valid && r_owner_in != '0 && cur_owner == r_owner_in) begin
                                r_valid[r_idx] <= 1'b0;
                                if (r_rcnt != '1) rcnt_n = r_rcnt + 1'b1;
                            end
                        end
                        default: begin
                            if (cur_due_ok) tot_n = r_total + 1'b1;
                        end
                    endcase
                    r_hit   <= hit_n;
                    r_rcnt  <= rcnt_n;
                    r_total <= tot_n;
                    r_idx   <= (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
                    if (r_idx == LAST_SLOT) begin
                        case (r_req)
                            REQ_CANCEL_ID: begin
                                if (hit_n) r_res <= '{ST_OK, r_target, '0, '0, 1'b0, 1'b1};
                                else r_res <= '{ST_NOT_FOUND, '0, '0, '0, 1'b0, 1'b1};
                                r_state <= S_EMIT;
                            end
                            REQ_QUERY: begin
                                if (hit_n) r_res <= '{ST_OK, '0, '0, '0, 1'b1, 1'b1};
                                else r_res <= '{ST_NOT_FOUND, '0, '0, '0, 1'b0, 1'b1};
                                r_state <= S_EMIT;
                            end
                            REQ_CANCEL_OWN: begin
                                r_res <= '{(rcnt_n != '0) ? ST_OK : ST_NONE, '0, '0,
                                           rcnt_n, 1'b0, 1'b1};
                                r_state <= S_EMIT;
                            end
                            default: begin
                                if (tot_n == '0) begin
                                    r_res   <= '{ST_NONE, '0, '0, '0, 1'b0, 1'b1};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_found <= 1'b0;
                                    r_state <= S_PICK;
                                end
                            end
                        endcase
                    end
                end

                // one slot per cycle: earliest due, ties to lower id
                S_PICK: begin : pick
                    logic              upd;
                    logic [SLOT_W-1:0] best_n;
                    logic [ID_W-1:0]   bid_n;
                    logic [ID_W-1:0]   bown_n;
                    upd    = cur_due_ok && cur_before;
                    best_n = upd ? r_idx : r_best;
                    bid_n  = upd ? cur_id : r_best_id;
                    bown_n = upd ? cur_owner : r_slot_owner[r_best];
                    if (upd) begin
                        r_found    <= 1'b1;
                        r_best     <= r_idx;
                        r_best_due <= cur_due;
                        r_best_id  <= cur_id;
                    end
                    r_idx <= (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
                    if (r_idx == LAST_SLOT) begin
                        r_valid[best_n] <= 1'b0;
                        r_fired         <= r_fired + 1'b1;
                        r_more          <= (r_fired + 1'b1 != r_total);
                        r_res <= '{ST_OK, bid_n, bown_n, '0, 1'b0,
                                   (r_fired + 1'b1 == r_total)};
                        r_state <= S_EMIT;
                    end
                end

                // hand the staged result to the output register
                S_EMIT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        if (r_more) begin
                            r_found <= 1'b0;
                            r_more  <= 1'b0;
                            r_state <= S_PICK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: tb/sv/tb_timed_task_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_task_queue: self-checking bench for the timed task queue
// Drives requests through the request channel, predicts every result with a
// local task table, and compares each whole result record in order. Runs
// directed corners, a long receiver hold-off and a pause test, then random traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_timed_task_queue;
    import ttq_pkg::*;

    logic i_clk;
    logic i_rst_n;

    ttq_req_if req_ch ();
    ttq_rsp_if rsp_ch ();

    timed_task_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // clock, 10 ns period
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // predicted task table
    logic              tbl_valid [TASK_SLOTS];
    logic [TIME_W-1:0] tbl_due   [TASK_SLOTS];
    logic [ID_W-1:0]   tbl_owner [TASK_SLOTS];
    logic [ID_W-1:0]   tbl_id    [TASK_SLOTS];
    logic [ID_W-1:0]   next_id_cnt;

    t_rsp expected_rsps[$];
    int   mismatch_cnt;
    int   send_idle_pct;   // sender idle chance, percent
    int   recv_stall_pct;  // receiver stall chance, percent
    int   hold_off_cycles; // long receiver hold-off, counted in its own process

    function automatic t_rsp mk_rsp(logic [STAT_W-1:0] st, logic [ID_W-1:0] id,
                                    logic [ID_W-1:0] own, logic [RCNT_W-1:0] cnt,
                                    logic pres, logic lst);
        t_rsp r;
        r.status = st; r.result_id = id; r.result_owner = own;
        r.removed_count = cnt; r.present = pres; r.last = lst;
        return r;
    endfunction

    // Work out the results of one accepted request and queue them.
    task automatic predict_queue(logic [REQ_W-1:0] rt, logic [TIME_W-1:0] due,
                                 logic [ID_W-1:0] own, logic [ID_W-1:0] tgt,
                                 logic [TIME_W-1:0] now);
        int free_slot;
        int cnt;
        int total;
        int best;
        bit hit;
        logic [ID_W-1:0] nid;
        free_slot = -1; cnt = 0; total = 0; hit = 0;
        case (rt)
            REQ_INS_SYS, REQ_INS_OWNED: begin
                for (int i = 0; i < TASK_SLOTS; i++)
                    if (!tbl_valid[i] && free_slot < 0) free_slot = i;
                if (free_slot < 0) begin
                    expected_rsps.push_back(mk_rsp(ST_FULL, 0, 0, 0, 0, 1));
                end else begin
                    nid = next_id_cnt + 1;
                    if (nid == 0) nid = 1;   // counter skips zero on wrap
                    next_id_cnt = nid;
                    tbl_valid[free_slot] = 1;
                    tbl_due[free_slot]   = due;
                    tbl_owner[free_slot] = (rt == REQ_INS_OWNED) ? own : '0;
                    tbl_id[free_slot]    = nid;
                    expected_rsps.push_back(mk_rsp(ST_OK, nid, tbl_owner[free_slot],
                                                   0, 0, 1));
                end
            end
            REQ_CANCEL_ID: begin
                if (tgt != 0)
                    for (int i = 0; i < TASK_SLOTS; i++)
                        if (tbl_valid[i] && tbl_id[i] == tgt) begin
                            tbl_valid[i] = 0; hit = 1;
                        end
                expected_rsps.push_back(hit ? mk_rsp(ST_OK, tgt, 0, 0, 0, 1)
                                            : mk_rsp(ST_NOT_FOUND, 0, 0, 0, 0, 1));
            end
            REQ_CANCEL_OWN: begin
                if (own != 0)
                    for (int i = 0; i < TASK_SLOTS; i++)
                        if (tbl_valid[i] && tbl_owner[i] == own) begin
                            tbl_valid[i] = 0; cnt++;
                        end
                if (cnt > 31) cnt = 31;
                expected_rsps.push_back(mk_rsp(cnt ? ST_OK : ST_NONE, 0, 0, cnt, 0, 1));
            end
            REQ_TICK: begin
                for (int i = 0; i < TASK_SLOTS; i++)
                    if (tbl_valid[i] && tbl_due[i] <= now) total++;
                if (total == 0)
                    expected_rsps.push_back(mk_rsp(ST_NONE, 0, 0, 0, 0, 1));
                for (int k = 0; k < total; k++) begin
                    best = -1;
                    for (int i = 0; i < TASK_SLOTS; i++) begin
                        if (!tbl_valid[i] || tbl_due[i] > now) continue;
                        if (best < 0 || tbl_due[i] < tbl_due[best] ||
                            (tbl_due[i] == tbl_due[best] && tbl_id[i] < tbl_id[best]))
                            best = i;
                    end
                    tbl_valid[best] = 0;
                    expected_rsps.push_back(mk_rsp(ST_OK, tbl_id[best], tbl_owner[best],
                                                   0, 0, k == total - 1));
                end
            end
            REQ_QUERY: begin
                if (tgt != 0)
                    for (int i = 0; i < TASK_SLOTS; i++)
                        if (tbl_valid[i] && tbl_id[i] == tgt) hit = 1;
                expected_rsps.push_back(mk_rsp(hit ? ST_OK : ST_NOT_FOUND, 0, 0, 0,
                                               hit, 1));
            end
            default: expected_rsps.push_back(mk_rsp(ST_NONE, 0, 0, 0, 0, 1));
        endcase
    endtask

    // Offer one item and hold it until accepted; predict at the accept edge.
    // valid stays high after the accept and drops when the sender idles.
    task automatic send_req(logic [REQ_W-1:0] rt, logic [TIME_W-1:0] due,
                            logic [ID_W-1:0] own, logic [ID_W-1:0] tgt,
                            logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rt;
        req_ch.due_time  <= due;
        req_ch.owner_id  <= own;
        req_ch.target_id <= tgt;
        req_ch.now_time  <= now;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_queue(rt, due, own, tgt, now);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver: random stalls, plus a long counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ch.ready    <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_rsp act;
        t_rsp exp_r;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            act = mk_rsp(rsp_ch.status, rsp_ch.result_id, rsp_ch.result_owner,
                         rsp_ch.removed_count, rsp_ch.present, rsp_ch.last);
            if (expected_rsps.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result %p", act);
            end else begin
                exp_r = expected_rsps.pop_front();
                if (act !== exp_r) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, act);
                end
            end
        end
    end

    function automatic logic [TIME_W-1:0] rnd_time();
        case ($urandom_range(3))
            0: return TIME_W'({$urandom, $urandom});
            default: return $urandom_range(200);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] rnd_owner();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 0;
            default: return $urandom_range(4, 1);
        endcase
    endfunction

    // pick a held id most of the time so cancel/query hit
    function automatic logic [ID_W-1:0] rnd_target();
        int s;
        s = $urandom_range(TASK_SLOTS - 1);
        if ($urandom_range(3) != 0 && tbl_valid[s]) return tbl_id[s];
        return ($urandom_range(1)) ? $urandom : next_id_cnt + $urandom_range(2);
    endfunction

    task automatic test_directed();
        send_req(REQ_TICK, 0, 0, 0, {TIME_W{1'b1}});          // empty tick
        send_req(REQ_CANCEL_ID, 0, 0, 0, 0);                  // id zero
        send_req(REQ_QUERY, 0, 0, 0, 0);
        send_req(REQ_CANCEL_OWN, 0, 0, 0, 0);                 // owner zero
        send_req(REQ_INS_SYS, {TIME_W{1'b1}}, 32'hFFFF_FFFF, 0, 0);
        send_req(REQ_INS_OWNED, 0, 32'hFFFF_FFFF, 0, 0);
        send_req(REQ_INS_OWNED, 5, 0, 0, 0);                  // owner 0 -> system
        send_req(REQ_INS_OWNED, 5, 7, 0, 0);                  // tie on due
        send_req(REQ_QUERY, 0, 0, 32'd2, 0);
        send_req(REQ_QUERY, 0, 0, 32'hFFFF_FFFF, 0);
        send_req(REQ_CANCEL_ID, 0, 0, 32'd1, 0);
        send_req(REQ_CANCEL_ID, 0, 0, 32'hFFFF_FFFF, 0);      // unknown id
        send_req(REQ_CANCEL_OWN, 0, 32'd9, 0, 0);             // owner without tasks
        send_req(3'd6, 0, 0, 0, 0);                           // unused codes
        send_req(3'd7, {TIME_W{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {TIME_W{1'b1}});
        send_req(REQ_TICK, 0, 0, 0, 5);
        // fill the table, overflow, then cancel all of one owner
        for (int i = 0; i < TASK_SLOTS; i++) send_req(REQ_INS_OWNED, i, 3, 0, 0);
        send_req(REQ_INS_SYS, 0, 0, 0, 0);                    // table full
        send_req(REQ_CANCEL_OWN, 0, 3, 0, 0);                 // removes all
        wait_drained();
    endtask

    task automatic test_random(int n);
        logic [REQ_W-1:0] rt;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2: rt = REQ_INS_OWNED;
                3:       rt = REQ_INS_SYS;
                4:       rt = REQ_CANCEL_ID;
                5:       rt = REQ_CANCEL_OWN;
                6, 7:    rt = REQ_TICK;
                8:       rt = REQ_QUERY;
                default: rt = $urandom_range(7);
            endcase
            send_req(rt, rnd_time(), rnd_owner(), rnd_target(), rnd_time());
        end
        wait_drained();
    endtask

    // Long receiver hold-off while a burst ticks many tasks at once.
    task automatic test_backpressure();
        for (int i = 0; i < TASK_SLOTS; i++) send_req(REQ_INS_OWNED, i, i, 0, 0);
        wait_drained();
        hold_off_cycles = 300;
        send_req(REQ_TICK, 0, 0, 0, {TIME_W{1'b1}});
        for (int i = 0; i < 4; i++) send_req(REQ_QUERY, 0, 0, next_id_cnt - i, 0);
        wait_drained();
    endtask

    // Sender goes quiet until every result is back, then ticks the task due.
    task automatic test_pause_then_send();
        send_req(REQ_INS_SYS, 10, 0, 0, 0);
        wait_drained();                    // sender pauses until all results
        send_req(REQ_TICK, 0, 0, 0, 10);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0; req_ch.req_type = '0; req_ch.due_time = '0;
        req_ch.owner_id = '0; req_ch.target_id = '0; req_ch.now_time = '0;
        rsp_ch.ready = 1'b0;
        mismatch_cnt = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
        for (int i = 0; i < TASK_SLOTS; i++) tbl_valid[i] = 0;
        next_id_cnt = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_pause_then_send();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(28);
        send_idle_pct = 56; recv_stall_pct = 0;  test_random(28);
        send_idle_pct = 0;  recv_stall_pct = 56; test_random(28);
        send_idle_pct = 36; recv_stall_pct = 36; test_random(29);
        repeat (2 * TASK_SLOTS + 10) @(posedge i_clk);

        if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
